// ----- rtl/core/clint_pkg.sv -----
// ----------------------------------------------------------------------------
// clint_pkg
// Address map, access sizes and command codes of the core-local interruptor.
// ----------------------------------------------------------------------------
package clint_pkg;

  localparam logic [63:0] BASE_ADDRESS   = 64'd33554432;
  localparam logic [63:0] SOFT_OFFSET    = 64'd0;
  localparam logic [63:0] COMPARE_OFFSET = 64'd16384;
  localparam logic [63:0] TIME_OFFSET    = 64'd49144;
  localparam logic [63:0] HALF_STEP      = 64'd4;

  localparam logic [63:0] SOFT_ADDR     = BASE_ADDRESS + SOFT_OFFSET;
  localparam logic [63:0] CMP_LO_ADDR   = BASE_ADDRESS + COMPARE_OFFSET;
  localparam logic [63:0] CMP_HI_ADDR   = BASE_ADDRESS + COMPARE_OFFSET + HALF_STEP;
  localparam logic [63:0] TIME_LO_ADDR  = BASE_ADDRESS + TIME_OFFSET;
  localparam logic [63:0] TIME_HI_ADDR  = BASE_ADDRESS + TIME_OFFSET + HALF_STEP;

  localparam logic [3:0] SIZE_WORD   = 4'd4;
  localparam logic [3:0] SIZE_DWORD  = 4'd8;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

endpackage

// ----- rtl/core/core_local_timer_interruptor.sv -----
// ----------------------------------------------------------------------------
// core_local_timer_interruptor
// Single-hart timer and software interrupt unit with a 64-bit time counter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item: a bus read, a bus
//   write or a tick that advances the time counter by in_tick_count.
//   Result channel (out_valid/out_ready) returns one item per input item:
//   read data, the timer and software pending flags, change flags and an
//   access error flag.
//   An accepted item passes the input register, then the decode, 64-bit add
//   and 64-bit compare into the state and the result register that drives
//   out_valid. Throughput is one item per cycle while out_ready stays high.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more item, then in_ready drops until out_ready returns.
//   Reset clears time, compare, the software bit, both pending flags and
//   both stage valids. Items are processed strictly in order.
// ----------------------------------------------------------------------------
module core_local_timer_interruptor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_bus_address,
  input  logic [3:0]  in_access_size,
  input  logic [63:0] in_write_data,
  input  logic [63:0] in_tick_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_read_data,
  output logic        out_timer_pending,
  output logic        out_software_pending,
  output logic        out_timer_flipped,
  output logic        out_software_flipped,
  output logic        out_access_error
);

  // input stage
  logic        s1_valid_r;
  clint_pkg::cmd_t s1_command_r;
  logic [63:0] s1_address_r;
  logic [3:0]  s1_size_r;
  logic [63:0] s1_data_r;
  logic [63:0] s1_ticks_r;

  // architectural state
  logic [63:0] time_count_r, time_count_nxt;
  logic [63:0] time_compare_r, time_compare_nxt;
  logic        soft_bit_r, soft_bit_nxt;
  logic        timer_flag_r, timer_flag_nxt;
  logic        soft_flag_r, soft_flag_nxt;

  // result register
  logic        out_valid_r;
  logic [63:0] read_data_r, read_data_nxt;
  logic        timer_chg_r, timer_chg_nxt;
  logic        soft_chg_r, soft_chg_nxt;
  logic        error_r, error_nxt;

  logic s1_advance;
  logic s1_fire;
  logic refresh;
  logic timer_now;

  logic hit_soft, hit_cmp_lo, hit_cmp_hi, hit_time_lo, hit_time_hi;
  logic size_w, size_d;

  assign s1_advance = !out_valid_r || out_ready;
  assign s1_fire    = s1_valid_r && s1_advance;
  assign in_ready   = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_command_r <= clint_pkg::cmd_t'(in_command);
      s1_address_r <= in_bus_address;
      s1_size_r    <= in_access_size;
      s1_data_r    <= in_write_data;
      s1_ticks_r   <= in_tick_count;
    end
  end

  assign size_w = (s1_size_r == clint_pkg::SIZE_WORD);
  assign size_d = (s1_size_r == clint_pkg::SIZE_DWORD);

  // decode priority: soft, compare low, time low, compare high, time high
  always_comb begin
    hit_soft    = (s1_address_r == clint_pkg::SOFT_ADDR);
    hit_cmp_lo  = !hit_soft && (s1_address_r == clint_pkg::CMP_LO_ADDR);
    hit_time_lo = !hit_soft && !hit_cmp_lo && (s1_address_r == clint_pkg::TIME_LO_ADDR);
    hit_cmp_hi  = !hit_soft && !hit_cmp_lo && !hit_time_lo && size_w &&
                  (s1_address_r == clint_pkg::CMP_HI_ADDR);
    hit_time_hi = !hit_soft && !hit_cmp_lo && !hit_time_lo && !hit_cmp_hi && size_w &&
                  (s1_address_r == clint_pkg::TIME_HI_ADDR);
  end

  always_comb begin
    time_count_nxt   = time_count_r;
    time_compare_nxt = time_compare_r;
    soft_bit_nxt     = soft_bit_r;
    read_data_nxt    = 64'd0;
    error_nxt        = 1'b0;
    refresh          = 1'b0;
    case (s1_command_r)
      clint_pkg::CMD_READ: begin
        if (hit_soft) begin
          if (size_w) read_data_nxt = {63'd0, soft_bit_r};
          else error_nxt = 1'b1;
        end else if (hit_cmp_lo) begin
          if (size_d) read_data_nxt = time_compare_r;
          else if (size_w) read_data_nxt = {32'd0, time_compare_r[31:0]};
          else error_nxt = 1'b1;
        end else if (hit_time_lo) begin
          if (size_d) read_data_nxt = time_count_r;
          else if (size_w) read_data_nxt = {32'd0, time_count_r[31:0]};
          else error_nxt = 1'b1;
        end else if (hit_cmp_hi) begin
          read_data_nxt = {32'd0, time_compare_r[63:32]};
        end else if (hit_time_hi) begin
          read_data_nxt = {32'd0, time_count_r[63:32]};
        end else begin
          error_nxt = 1'b1;
        end
      end
      clint_pkg::CMD_WRITE: begin
        if (hit_soft) begin
          if (size_w) begin
            soft_bit_nxt = s1_data_r[0];
            refresh      = 1'b1;
          end else begin
            error_nxt = 1'b1;
          end
        end else if (hit_cmp_lo) begin
          if (size_d) time_compare_nxt = s1_data_r;
          else if (size_w) time_compare_nxt = {time_compare_r[63:32], s1_data_r[31:0]};
          else error_nxt = 1'b1;
          refresh = 1'b1;
        end else if (hit_time_lo) begin
          if (size_d) time_count_nxt = s1_data_r;
          else if (size_w) time_count_nxt = {time_count_r[63:32], s1_data_r[31:0]};
          else error_nxt = 1'b1;
          refresh = 1'b1;
        end else if (hit_cmp_hi) begin
          time_compare_nxt = {s1_data_r[31:0], time_compare_r[31:0]};
          refresh          = 1'b1;
        end else if (hit_time_hi) begin
          time_count_nxt = {s1_data_r[31:0], time_count_r[31:0]};
          refresh        = 1'b1;
        end else begin
          error_nxt = 1'b1;
        end
      end
      clint_pkg::CMD_TICK: begin
        if (s1_ticks_r != 64'd0) begin
          time_count_nxt = time_count_r + s1_ticks_r;
          refresh        = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    timer_now      = (time_count_nxt >= time_compare_nxt);
    timer_flag_nxt = refresh ? timer_now : timer_flag_r;
    soft_flag_nxt  = refresh ? soft_bit_nxt : soft_flag_r;
    timer_chg_nxt  = refresh && (timer_now != timer_flag_r);
    soft_chg_nxt   = refresh && (soft_bit_nxt != soft_flag_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_count_r   <= 64'd0;
      time_compare_r <= 64'd0;
      soft_bit_r     <= 1'b0;
      timer_flag_r   <= 1'b0;
      soft_flag_r    <= 1'b0;
    end else if (s1_fire) begin
      time_count_r   <= time_count_nxt;
      time_compare_r <= time_compare_nxt;
      soft_bit_r     <= soft_bit_nxt;
      timer_flag_r   <= timer_flag_nxt;
      soft_flag_r    <= soft_flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      read_data_r <= read_data_nxt;
      timer_chg_r <= timer_chg_nxt;
      soft_chg_r  <= soft_chg_nxt;
      error_r     <= error_nxt;
    end
  end

  // flags are only updated together with the result register
  assign out_valid            = out_valid_r;
  assign out_read_data        = read_data_r;
  assign out_timer_pending    = timer_flag_r;
  assign out_software_pending = soft_flag_r;
  assign out_timer_flipped    = timer_chg_r;
  assign out_software_flipped = soft_chg_r;
  assign out_access_error     = error_r;

`ifndef ASSERT_OFF
  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && error_r |-> read_data_r == 64'd0)
    else $error("access error with nonzero read data");

  a_read_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_command_r == clint_pkg::CMD_READ |=> !timer_chg_r && !soft_chg_r)
    else $error("read changed a pending flag");

  a_zero_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_command_r == clint_pkg::CMD_TICK && s1_ticks_r == 64'd0
    |=> $stable(time_count_r) && !timer_chg_r && !soft_chg_r)
    else $error("zero tick changed state");

  a_chg_toggles: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> timer_chg_r == (timer_flag_r != $past(timer_flag_r)))
    else $error("timer change flag does not match pending flag");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(time_count_r) && $stable(time_compare_r))
    else $error("state updated while result stalled");
`endif

endmodule
